// File: rtl/pdts_pkg.sv
// Shared types, constants and table functions of the decaying tone synthesizer.
package pdts_pkg;

    localparam int AMP_W       = 31;
    localparam int DECAY_W     = 24;
    localparam int FRAC_W      = 24;
    localparam int SINE_MAG_W  = 15;
    localparam int SINE_SHIFT  = 15;
    localparam int SAMPLE_W    = 32;
    localparam int KEY_W       = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [AMP_W-1:0]   NOTE_VOLUME_RESET  = 31'd165191049;
    localparam logic [DECAY_W-1:0] DECAY_FACTOR_RESET = 24'd16772185;

    localparam logic [CFG_INDEX_W-1:0] REG_NOTE_VOLUME  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_FACTOR = 8'd1;

    typedef enum logic [1:0]
    {
        OP_TICK    = 2'd0,
        OP_KEY     = 2'd1,
        OP_SILENCE = 2'd2
    } op_t;

    localparam logic [63:0] RATE_MHZ    = 64'd8000000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

    localparam logic [19:0] PITCH_MHZ [32] = '{
        20'd277183, 20'd311127, 20'd0,      20'd369994, 20'd415305, 20'd466164,
        20'd261626, 20'd293665, 20'd329628, 20'd349228, 20'd391995, 20'd440000,
        20'd493883, 20'd523251,
        20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
        20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0
    };

    // Quarter-wave sine entry j of a quarter of 2^qbits entries, Q0.15 magnitude.
    function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned j,
                                                           input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] acc;
        logic [63:0] scaled;
        x = (64'(j) * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        term = x;
        acc = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        acc = acc - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        acc = acc + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        acc = acc - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        acc = acc + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        acc = acc - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        acc = acc + signed'(term);
        term = ((term * x2) >> 30) / 64'd210;
        acc = acc - signed'(term);
        if (acc < 0)
        begin
            acc = 64'sd0;
        end
        if (acc > ONE_Q30)
        begin
            acc = ONE_Q30;
        end
        scaled = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
        return scaled[SINE_MAG_W-1:0];
    endfunction

endpackage

// File: rtl/pdts_if.sv
// Valid/ready channel interfaces for commands, audio samples and register writes.
interface pdts_cmd_if
    import pdts_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [1:0]       operation;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output operation, output key_code, input ready);
    modport sink (input valid, input operation, input key_code, output ready);
endinterface

interface pdts_audio_if
    import pdts_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface pdts_cfg_if
    import pdts_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/polyphonic_decaying_tone_synth.sv
// Polyphonic sine synthesizer with per-sample exponential amplitude decay.
//
// The cmd channel takes one word per command: a sample tick, a key press
// carrying a key code, or a silence command. The cfg channel writes the note
// volume (index 0) and the Q0.24 decay factor (index 1); it is always ready.
// Each tick yields one word on the audio channel, the saturated sum of all
// voices; key presses and silence yield nothing. A tick walks the voices one
// per cycle through the amplitude and phase memories, each with a single read
// and a single write port, followed by a three-stage multiply and accumulate
// pipe. The result appears on the audio channel in the same cycle that cmd is
// ready again, so the block takes no new tick until the last one is through.
// Reset clears every amplitude and phase at once through per-voice valid
// bits and loads the register defaults. When the receiver stalls, the held
// sample stays put while cmd keeps taking words; a tick that completes before
// the held sample is taken waits in its final state until the slot is free.
module polyphonic_decaying_tone_synth
    import pdts_pkg::*;
#(
    parameter int NUM_VOICES      = 14,
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    pdts_cmd_if.sink       cmd,
    pdts_audio_if.source   audio,
    pdts_cfg_if.sink       cfg
);

    localparam int VW       = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int QBITS    = SINE_TABLE_BITS - 2;
    localparam int QUARTER  = 1 << QBITS;
    localparam int DPROD_W  = AMP_W + DECAY_W;
    localparam int PROD_W   = AMP_W + SINE_MAG_W;
    localparam int ACC_W    = SAMPLE_W + 1 + $clog2(NUM_VOICES + 1);
    localparam logic [VW-1:0] LAST_VOICE = VW'(NUM_VOICES - 1);
    localparam logic [QBITS:0] QUARTER_IDX = {1'b1, {QBITS{1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    logic [SINE_MAG_W-1:0] quarter_rom [QUARTER+1];
    logic [PHASE_BITS-1:0] step_rom [NUM_VOICES];

    for (genvar j = 0; j <= QUARTER; j++)
    begin : g_quarter_rom
        localparam logic [SINE_MAG_W-1:0] VAL = quarter_sine(j, QBITS);
        assign quarter_rom[j] = VAL;
    end

    for (genvar v = 0; v < NUM_VOICES; v++)
    begin : g_step_rom
        localparam logic [63:0] STEP_FULL =
            ((64'(PITCH_MHZ[v]) << PHASE_BITS) + (RATE_MHZ >> 1)) / RATE_MHZ;
        assign step_rom[v] = STEP_FULL[PHASE_BITS-1:0];
    end

    state_t                     state_reg;
    logic [AMP_W-1:0]           note_volume_reg;
    logic [DECAY_W-1:0]         decay_factor_reg;
    logic [VW-1:0]              rd_idx_reg;
    logic                       p1_reg;
    logic                       p2_reg;
    logic                       p3_reg;
    logic [VW-1:0]              v1_reg;
    logic [VW-1:0]              v2_reg;
    logic [AMP_W-1:0]           amp_s2_reg;
    logic [SINE_MAG_W-1:0]      mag_s2_reg;
    logic                       neg_s2_reg;
    logic [DPROD_W-1:0]         dprod_s2_reg;
    logic [PROD_W-1:0]          prod_s3_reg;
    logic                       neg_s3_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       out_valid_reg;
    logic [NUM_VOICES-1:0]      amp_valid_reg;
    logic [NUM_VOICES-1:0]      phase_valid_reg;
    logic                       amp_rd_vld_reg;
    logic                       phase_rd_vld_reg;

    logic [AMP_W-1:0]           amp_mem [NUM_VOICES];
    logic [PHASE_BITS-1:0]      phase_mem [NUM_VOICES];
    logic [AMP_W-1:0]           amp_rd_reg;
    logic [PHASE_BITS-1:0]      phase_rd_reg;

    logic                       cmd_fire;
    logic [KEY_W-1:0]           key_target_wide;
    logic                       key_hit;
    logic                       amp_we;
    logic [VW-1:0]              amp_waddr;
    logic [AMP_W-1:0]           amp_wdata;
    logic [AMP_W-1:0]           amp_cur;
    logic [PHASE_BITS-1:0]      phase_cur;
    logic [PHASE_BITS-1:0]      phase_wdata;
    logic [SINE_TABLE_BITS-1:0] table_idx;
    logic [QBITS:0]             rom_addr;
    logic [ACC_W-1:0]           term_ext;
    logic                       out_load;
    logic signed [SAMPLE_W-1:0] sample_next;

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;
    assign audio.valid = out_valid_reg;
    assign audio.sample = sample_reg;

    assign cmd_fire = cmd.valid && cmd.ready;

    always_comb
    begin
        key_target_wide = '1;
        if (cmd.key_code >= 8'd3 && cmd.key_code <= 8'd8)
        begin
            key_target_wide = cmd.key_code - 8'd3;
        end
        else if (cmd.key_code >= 8'd16 && cmd.key_code <= 8'd23)
        begin
            key_target_wide = cmd.key_code - 8'd10;
        end
    end

    assign key_hit = cmd_fire && (op_t'(cmd.operation) == OP_KEY)
                     && (key_target_wide < KEY_W'(NUM_VOICES));

    assign amp_cur     = amp_rd_vld_reg ? amp_rd_reg : '0;
    assign phase_cur   = phase_rd_vld_reg ? phase_rd_reg : '0;
    assign phase_wdata = phase_cur + step_rom[v1_reg];
    assign table_idx   = phase_cur[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign rom_addr    = table_idx[QBITS] ? (QUARTER_IDX - {1'b0, table_idx[QBITS-1:0]})
                                          : {1'b0, table_idx[QBITS-1:0]};

    assign amp_we    = p2_reg || key_hit;
    assign amp_waddr = p2_reg ? v2_reg : key_target_wide[VW-1:0];
    assign amp_wdata = p2_reg ? dprod_s2_reg[DPROD_W-1 -: AMP_W] : note_volume_reg;

    assign term_ext = {{(ACC_W-AMP_W){1'b0}}, prod_s3_reg[PROD_W-1 -: AMP_W]};

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || audio.ready);

    always_comb
    begin
        if (acc_reg > SAT_MAX)
        begin
            sample_next = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (acc_reg < SAT_MIN)
        begin
            sample_next = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            sample_next = acc_reg[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (amp_we)
        begin
            amp_mem[amp_waddr] <= amp_wdata;
        end
        amp_rd_reg <= amp_mem[rd_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (p1_reg)
        begin
            phase_mem[v1_reg] <= phase_wdata;
        end
        phase_rd_reg <= phase_mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_valid_reg    <= '0;
            phase_valid_reg  <= '0;
            amp_rd_vld_reg   <= 1'b0;
            phase_rd_vld_reg <= 1'b0;
        end
        else
        begin
            amp_rd_vld_reg   <= amp_valid_reg[rd_idx_reg];
            phase_rd_vld_reg <= phase_valid_reg[rd_idx_reg];
            if (cmd_fire && (op_t'(cmd.operation) == OP_SILENCE))
            begin
                amp_valid_reg <= '0;
            end
            else if (amp_we)
            begin
                amp_valid_reg[amp_waddr] <= 1'b1;
            end
            if (p1_reg)
            begin
                phase_valid_reg[v1_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_volume_reg  <= NOTE_VOLUME_RESET;
            decay_factor_reg <= DECAY_FACTOR_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_NOTE_VOLUME:  note_volume_reg  <= cfg.data[AMP_W-1:0];
                REG_DECAY_FACTOR: decay_factor_reg <= cfg.data[DECAY_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        v1_reg       <= rd_idx_reg;
        v2_reg       <= v1_reg;
        amp_s2_reg   <= amp_cur;
        mag_s2_reg   <= quarter_rom[rom_addr];
        neg_s2_reg   <= table_idx[SINE_TABLE_BITS-1];
        dprod_s2_reg <= DPROD_W'(amp_cur) * DPROD_W'(decay_factor_reg);
        prod_s3_reg  <= PROD_W'(amp_s2_reg) * PROD_W'(mag_s2_reg);
        neg_s3_reg   <= neg_s2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            p3_reg        <= 1'b0;
            acc_reg       <= '0;
            sample_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= (state_reg == ST_RUN);
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            if (p3_reg)
            begin
                acc_reg <= neg_s3_reg ? (acc_reg - signed'(term_ext))
                                      : (acc_reg + signed'(term_ext));
            end
            if (out_load)
            begin
                sample_reg    <= sample_next;
                out_valid_reg <= 1'b1;
            end
            else if (audio.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire && (op_t'(cmd.operation) == OP_TICK))
                    begin
                        rd_idx_reg <= '0;
                        acc_reg    <= '0;
                        state_reg  <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (rd_idx_reg == LAST_VOICE)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (!p1_reg && !p2_reg && !p3_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: test/tb.sv
// Self-checking testbench for the polyphonic decaying tone synthesizer.
`timescale 1ns / 1ps

module tb;
    import pdts_pkg::*;

    localparam int VOICES          = 14;
    localparam int TABLE_BITS      = 10;
    localparam int TABLE_SIZE      = 1 << TABLE_BITS;
    localparam int QUARTER         = TABLE_SIZE / 4;
    localparam int TICK_LATENCY    = VOICES + 5;
    localparam int SETTLE_CYCLES   = 2 * TICK_LATENCY;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 232;
    localparam int SCRIPT_LEN      = 30;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = 8'd255;

    localparam int SEND_IDLE [4]  = '{0, 81, 0, 31};
    localparam int RECV_STALL [4] = '{0, 0, 81, 31};

    typedef struct packed
    {
        logic                   is_cfg;
        logic [1:0]             op;
        logic [KEY_W-1:0]       key;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   typed;
        logic [SAMPLE_W-1:0]    want;
    } step_row_t;

    // Directed opening: register rows are written once the block has gone quiet.
    localparam step_row_t SCRIPT [SCRIPT_LEN] = '{
        '{1'b0, OP_TICK,    8'd0,   REG_NOTE_VOLUME,  32'd0,          1'b1, 32'd0},
        '{1'b0, OP_KEY,     8'd3,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd23,  REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd0,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd255, REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd2,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd9,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd15,  REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd16,  REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd8,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_TICK,    8'd0,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_TICK,    8'd255, REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_UNUSED,  8'd3,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_TICK,    8'd0,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_SILENCE, 8'd0,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_TICK,    8'd0,   REG_NOTE_VOLUME,  32'd0,          1'b1, 32'd0},
        '{1'b1, OP_TICK,    8'd0,   REG_NOTE_VOLUME,  32'hFFFF_FFFF,  1'b0, 32'd0},
        '{1'b1, OP_TICK,    8'd0,   REG_DECAY_FACTOR, 32'hFFFF_FFFF,  1'b0, 32'd0},
        '{1'b1, OP_TICK,    8'd0,   REG_UNUSED_LOW,   32'd0,          1'b0, 32'd0},
        '{1'b1, OP_TICK,    8'd0,   REG_UNUSED_TOP,   32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd5,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd6,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd17,  REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_KEY,     8'd19,  REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_TICK,    8'd0,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_TICK,    8'd0,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_TICK,    8'd0,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b1, OP_TICK,    8'd0,   REG_DECAY_FACTOR, 32'd0,          1'b0, 32'd0},
        '{1'b0, OP_TICK,    8'd0,   REG_NOTE_VOLUME,  32'd0,          1'b0, 32'd0},
        '{1'b0, OP_TICK,    8'd0,   REG_NOTE_VOLUME,  32'd0,          1'b1, 32'd0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pdts_cmd_if   cmd_ch ();
    pdts_audio_if audio_ch ();
    pdts_cfg_if   cfg_ch ();

    polyphonic_decaying_tone_synth #(
        .NUM_VOICES      (VOICES),
        .SINE_TABLE_BITS (TABLE_BITS),
        .PHASE_BITS      (32)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .audio (audio_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [AMP_W-1:0]   amp_state [VOICES];
    logic [31:0]        phase_state [VOICES];
    logic [31:0]        phase_inc [VOICES];
    int                 wave_tbl [TABLE_SIZE];
    logic [AMP_W-1:0]   vol_reg;
    logic [DECAY_W-1:0] decay_reg;

    logic signed [SAMPLE_W-1:0] pending_samples [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int commands_sent = 0;
    int ticks_sent = 0;
    int samples_checked = 0;
    int reg_settings = 0;
    int mismatches = 0;

    function automatic int sine_quarter(input int unsigned j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        int          k;
        x = (64'(j) * HALF_PI_Q30) / 64'(QUARTER);
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (k = 1; k <= 7; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        if (acc > ONE_Q30)
        begin
            acc = ONE_Q30;
        end
        return int'((64'(acc) * 64'd32767 + 64'd536870912) >> 30);
    endfunction

    function automatic int voice_of(input logic [KEY_W-1:0] key);
        if (key >= 8'd3 && key <= 8'd8)
        begin
            return int'(key) - 3;
        end
        if (key >= 8'd16 && key <= 8'd23)
        begin
            return int'(key) - 10;
        end
        return -1;
    endfunction

    task automatic reset_synth_model();
        int i;
        int quad;
        int r;
        vol_reg = NOTE_VOLUME_RESET;
        decay_reg = DECAY_FACTOR_RESET;
        for (i = 0; i < VOICES; i++)
        begin
            amp_state[i] = '0;
            phase_state[i] = '0;
            phase_inc[i] = 32'(((64'(PITCH_MHZ[i]) << 32) + RATE_MHZ / 2) / RATE_MHZ);
        end
        for (i = 0; i < TABLE_SIZE; i++)
        begin
            quad = i / QUARTER;
            r = i % QUARTER;
            case (quad)
                0: wave_tbl[i] = sine_quarter(r);
                1: wave_tbl[i] = sine_quarter(QUARTER - r);
                2: wave_tbl[i] = -sine_quarter(r);
                default: wave_tbl[i] = -sine_quarter(QUARTER - r);
            endcase
        end
    endtask

    // Mixes the current voices into one sample, then decays and advances them.
    function automatic logic signed [SAMPLE_W-1:0] render_tick();
        longint total;
        int     i;
        total = 0;
        for (i = 0; i < VOICES; i++)
        begin
            total += (longint'(amp_state[i]) * longint'(wave_tbl[phase_state[i][31:22]]))
                     / 64'sd32768;
        end
        if (total > 64'sd2147483647)
        begin
            total = 64'sd2147483647;
        end
        else if (total < -64'sd2147483648)
        begin
            total = -64'sd2147483648;
        end
        for (i = 0; i < VOICES; i++)
        begin
            amp_state[i] = AMP_W'((64'(amp_state[i]) * 64'(decay_reg)) >> FRAC_W);
            phase_state[i] = phase_state[i] + phase_inc[i];
        end
        return total[31:0];
    endfunction

    task automatic take_command(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                output bit yields, output logic signed [SAMPLE_W-1:0] smp);
        int v;
        int i;
        yields = 1'b0;
        smp = '0;
        v = voice_of(key);
        case (op)
            OP_TICK:
            begin
                smp = render_tick();
                yields = 1'b1;
            end
            OP_KEY:
            begin
                if (v >= 0 && v < VOICES)
                begin
                    amp_state[v] = vol_reg;
                end
            end
            OP_SILENCE:
            begin
                for (i = 0; i < VOICES; i++)
                begin
                    amp_state[i] = '0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
        begin
            $display("ERROR: %s", what);
        end
        mismatches++;
    endtask

    task automatic send_command(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                input bit typed, input logic signed [SAMPLE_W-1:0] want);
        bit                         yields;
        logic signed [SAMPLE_W-1:0] smp;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.operation <= op;
        cmd_ch.key_code <= key;
        do
        begin
            @(posedge clk);
        end
        while (!cmd_ch.ready);
        take_command(op, key, yields, smp);
        if (yields)
        begin
            pending_samples.push_back(typed ? want : smp);
            ticks_sent++;
        end
        commands_sent++;
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit keep_valid);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        if (idx == REG_NOTE_VOLUME)
        begin
            vol_reg = data[AMP_W-1:0];
        end
        else if (idx == REG_DECAY_FACTOR)
        begin
            decay_reg = data[DECAY_W-1:0];
        end
        if (!keep_valid)
        begin
            cfg_ch.valid <= 1'b0;
        end
    endtask

    initial
    begin
        audio_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_left = HOLD_CYCLES;
                hold_served = hold_requests;
            end
            if (!rst_n || hold_left != 0)
            begin
                audio_ch.ready <= 1'b0;
                if (hold_left != 0)
                begin
                    hold_left--;
                end
            end
            else
            begin
                audio_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] exp_smp;
        if (rst_n)
        begin
            if (audio_ch.valid && audio_ch.ready)
            begin
                if (pending_samples.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected sample %0d", audio_ch.sample));
                end
                else
                begin
                    exp_smp = pending_samples.pop_front();
                    if (audio_ch.sample !== exp_smp)
                    begin
                        report_mismatch($sformatf("sample %0d: got %0d, expected %0d",
                                                  samples_checked, audio_ch.sample, exp_smp));
                    end
                    samples_checked++;
                end
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (audio_ch.valid && audio_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no word moved in %0d cycles, %0d samples outstanding",
                         quiet_cycles, pending_samples.size());
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        step_row_t           row;
        int                  p;
        int                  n;
        int                  counted;
        int                  pick;
        int                  v;
        logic [1:0]          op;
        logic [KEY_W-1:0]    key;
        logic [CFG_DATA_W-1:0] vol_data;
        logic [CFG_DATA_W-1:0] decay_data;

        cmd_ch.valid <= 1'b0;
        cmd_ch.operation <= OP_TICK;
        cmd_ch.key_code <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        reset_synth_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < SCRIPT_LEN; n++)
        begin
            row = SCRIPT[n];
            if (row.is_cfg)
            begin
                settle();
                write_reg(row.idx, row.data, 1'b0);
                reg_settings++;
            end
            else
            begin
                send_command(row.op, row.key, row.typed, row.want);
            end
        end

        for (p = 0; p < PHASES; p++)
        begin
            settle();
            send_idle_pct = SEND_IDLE[p % 4];
            recv_stall_pct = RECV_STALL[p % 4];
            case (p)
                0:
                begin
                    vol_data = 32'(NOTE_VOLUME_RESET);
                    decay_data = 32'(DECAY_FACTOR_RESET);
                end
                1:
                begin
                    vol_data = 32'hFFFF_FFFF;
                    decay_data = 32'hFFFF_FFFF;
                end
                2:
                begin
                    vol_data = 32'd0;
                    decay_data = 32'h00FF_FFFF;
                end
                4:
                begin
                    vol_data = $urandom;
                    decay_data = 32'd0;
                end
                default:
                begin
                    vol_data = $urandom;
                    decay_data = {8'($urandom), 24'hFF_FFFF - 24'($urandom_range(65535))};
                end
            endcase
            write_reg(REG_NOTE_VOLUME, vol_data, 1'b1);
            write_reg(REG_DECAY_FACTOR, decay_data, 1'b0);
            reg_settings++;
            // The receiver goes deaf for a long stretch while commands keep coming.
            if (p == 4)
            begin
                hold_requests <= hold_requests + 1;
            end
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(99);
                key = 8'($urandom);
                if (pick < 55)
                begin
                    op = OP_TICK;
                end
                else if (pick < 90)
                begin
                    op = OP_KEY;
                    v = $urandom_range(VOICES - 1);
                    if ($urandom_range(9) < 8)
                    begin
                        key = 8'(v < 6 ? v + 3 : v + 10);
                    end
                end
                else
                begin
                    op = OP_SILENCE;
                end
                counted++;
                send_command(op, key, 1'b0, '0);
            end
        end

        settle();
        $display("Summary: %0d commands including %0d ticks over %0d register settings.",
                 commands_sent, ticks_sent, reg_settings);
        $display("Summary: %0d samples compared, %0d mismatches.", samples_checked, mismatches);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/pdts_pkg.sv
rtl/pdts_if.sv
rtl/polyphonic_decaying_tone_synth.sv
test/tb.sv
